>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GEMT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define GEMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GEMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gemt_pkg.sv
`timescale 1ns / 1ps

package gemt_pkg;

   localparam int DOMAIN_SLOTS = 16;
   localparam int PAIRS_PER_DOMAIN = 16;
   localparam int MAX_RESULTS = 16;
   localparam int TOTAL_PAIRS = DOMAIN_SLOTS * PAIRS_PER_DOMAIN;

   localparam int SLOT_W = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
   localparam int PAIR_W = (PAIRS_PER_DOMAIN > 1) ? $clog2(PAIRS_PER_DOMAIN) : 1;
   localparam int ENTRY_W = (TOTAL_PAIRS > 1) ? $clog2(TOTAL_PAIRS) : 1;
   localparam int CNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam int CMD_W = 3;
   localparam int FABRIC_W = 8;
   localparam int GROUP_W = 16;
   localparam int ENDPOINT_W = 16;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_EXISTS = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIST = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN_DOMAIN = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef enum logic {
      EMIT_CODE,
      EMIT_PEND
   } emit_sel_type;

   typedef struct packed {
      logic load;
      logic slot_step;
      logic pair_start;
      logic pair_adv;
      logic pair_write;
      logic pair_clear_one;
      logic pair_clear_row;
      logic list_take;
      logic emit;
      emit_sel_type emit_sel;
      logic [STATUS_W-1:0] emit_status;
      logic emit_found;
      logic emit_last;
   } gemt_cmd_type;

   typedef struct packed {
      logic enabled;
      logic [CMD_W-1:0] command;
      logic slot_end;
      logic slot_found;
      logic chk_valid;
      logic chk_last;
      logic chk_match;
      logic chk_ep_match;
      logic pfree_any;
      logic pend_valid;
      logic list_full;
      logic out_free;
   } gemt_sts_type;

endpackage

>>> rtl/gemt_req_if.sv
`timescale 1ns / 1ps

interface gemt_req_if;
   import gemt_pkg::*;

   logic valid;
   logic ready;
   logic [CMD_W-1:0] command;
   logic [FABRIC_W-1:0] fabric_id;
   logic [GROUP_W-1:0] group_id;
   logic [ENDPOINT_W-1:0] endpoint_id;

   modport source (output valid, output command, output fabric_id, output group_id,
                   output endpoint_id, input ready);
   modport sink (input valid, input command, input fabric_id, input group_id,
                 input endpoint_id, output ready);
endinterface

>>> rtl/gemt_rsp_if.sv
`timescale 1ns / 1ps

interface gemt_rsp_if;
   import gemt_pkg::*;

   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic found;
   logic [GROUP_W-1:0] listed_group;
   logic last;

   modport source (output valid, output status, output found, output listed_group,
                   output last, input ready);
   modport sink (input valid, input status, input found, input listed_group,
                 input last, output ready);
endinterface

>>> rtl/gemt_datapath.sv
`timescale 1ns / 1ps

module gemt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data,
   input  logic [gemt_pkg::CMD_W-1:0]      req_command,
   input  logic [gemt_pkg::FABRIC_W-1:0]   req_fabric_id,
   input  logic [gemt_pkg::GROUP_W-1:0]    req_group_id,
   input  logic [gemt_pkg::ENDPOINT_W-1:0] req_endpoint_id,
   input  gemt_pkg::gemt_cmd_type         cmd,
   output gemt_pkg::gemt_sts_type         sts,
   gemt_rsp_if.source                     rsp
);
   import gemt_pkg::*;

   logic enabled_ff, enabled_in;

   // Latched item.
   logic [CMD_W-1:0] item_cmd_ff, item_cmd_in;
   logic [FABRIC_W-1:0] dom_ff, dom_in;
   logic [GROUP_W-1:0] grp_ff, grp_in;
   logic [ENDPOINT_W-1:0] ep_ff, ep_in;

   // Domain slot table.
   logic [DOMAIN_SLOTS-1:0] slot_used_ff, slot_used_in;
   logic [FABRIC_W-1:0] slot_domain_ff [DOMAIN_SLOTS];
   logic [FABRIC_W-1:0] slot_domain_in [DOMAIN_SLOTS];
   logic [SLOT_W-1:0] slot_ptr_ff, slot_ptr_in;
   logic [SLOT_W-1:0] slot_sel_ff, slot_sel_in;
   logic [SLOT_W-1:0] sfree_idx_ff, sfree_idx_in;
   logic sfree_valid_ff, sfree_valid_in;
   logic hit_now, free_now, slot_last, sfree_any, slot_end, slot_found;
   logic [SLOT_W-1:0] sfree_pick;

   // Pair table and its scan pipeline.
   logic [TOTAL_PAIRS-1:0] pair_used_ff, pair_used_in;
   logic [GROUP_W+ENDPOINT_W-1:0] pair_mem [TOTAL_PAIRS];
   logic [GROUP_W-1:0] rd_group_ff;
   logic [ENDPOINT_W-1:0] rd_ep_ff;
   logic [ENTRY_W-1:0] base, rd_addr, chk_addr, pick_addr;
   logic [PAIR_W-1:0] pair_ptr_ff, pair_ptr_in;
   logic [PAIR_W-1:0] chk_idx_ff, chk_idx_in;
   logic [PAIR_W-1:0] pfree_idx_ff, pfree_idx_in;
   logic [PAIR_W-1:0] pfree_pick;
   logic issue_ff, issue_in;
   logic chk_valid_ff, chk_valid_in;
   logic pfree_valid_ff, pfree_valid_in;
   logic chk_used, chk_match, chk_ep_match, chk_last, pfree_any;

   // List results waiting for the next match to learn whether they are last.
   logic pend_valid_ff, pend_valid_in;
   logic [GROUP_W-1:0] pend_group_ff, pend_group_in;
   logic [CNT_W-1:0] list_cnt_ff, list_cnt_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_found_ff, rsp_found_in;
   logic [GROUP_W-1:0] rsp_group_ff, rsp_group_in;
   logic rsp_last_ff, rsp_last_in;
   logic out_free;

   always_comb begin
      enabled_in = csr_wr_en ? csr_wr_data : enabled_ff;
      item_cmd_in = item_cmd_ff;
      dom_in = dom_ff;
      grp_in = grp_ff;
      ep_in = ep_ff;
      if (cmd.load) begin
         item_cmd_in = req_command;
         dom_in = req_fabric_id;
         grp_in = req_group_id;
         ep_in = req_endpoint_id;
      end
   end

   // Slot scan: one slot per step, stops at the first slot holding the domain.
   assign slot_last = (slot_ptr_ff == SLOT_W'(DOMAIN_SLOTS - 1));
   assign hit_now = slot_used_ff[slot_ptr_ff] && (slot_domain_ff[slot_ptr_ff] == dom_ff);
   assign free_now = !slot_used_ff[slot_ptr_ff];
   assign sfree_any = sfree_valid_ff || free_now;
   assign sfree_pick = sfree_valid_ff ? sfree_idx_ff : slot_ptr_ff;
   assign slot_end = hit_now || slot_last;
   assign slot_found = hit_now || (slot_last && (item_cmd_ff == CMD_ADD) && sfree_any);

   always_comb begin
      slot_ptr_in = slot_ptr_ff;
      slot_sel_in = slot_sel_ff;
      sfree_idx_in = sfree_idx_ff;
      sfree_valid_in = sfree_valid_ff;
      slot_used_in = slot_used_ff;
      slot_domain_in = slot_domain_ff;
      if (cmd.load) begin
         slot_ptr_in = '0;
         sfree_valid_in = 1'b0;
      end else if (cmd.slot_step) begin
         if (!slot_end) begin
            slot_ptr_in = slot_ptr_ff + 1'b1;
         end
         if (free_now && !sfree_valid_ff) begin
            sfree_valid_in = 1'b1;
            sfree_idx_in = slot_ptr_ff;
         end
         if (slot_end && slot_found) begin
            if (hit_now) begin
               slot_sel_in = slot_ptr_ff;
            end else begin
               // An add claims the lowest free slot for its domain.
               slot_sel_in = sfree_pick;
               slot_used_in[sfree_pick] = 1'b1;
               slot_domain_in[sfree_pick] = dom_ff;
            end
         end
      end
   end

   // Pair scan: an entry's address is issued, and its data registered, one advance ahead of its check.
   assign base = ENTRY_W'(int'(slot_sel_ff) * PAIRS_PER_DOMAIN);
   assign rd_addr = base + ENTRY_W'(pair_ptr_ff);
   assign chk_addr = base + ENTRY_W'(chk_idx_ff);
   assign chk_used = pair_used_ff[chk_addr];
   assign chk_match = chk_used && (rd_group_ff == grp_ff) && (rd_ep_ff == ep_ff);
   assign chk_ep_match = chk_used && (rd_ep_ff == ep_ff);
   assign chk_last = (chk_idx_ff == PAIR_W'(PAIRS_PER_DOMAIN - 1));
   assign pfree_any = pfree_valid_ff || (chk_valid_ff && !chk_used);
   assign pfree_pick = pfree_valid_ff ? pfree_idx_ff : chk_idx_ff;
   assign pick_addr = base + ENTRY_W'(pfree_pick);

   always_comb begin
      pair_ptr_in = pair_ptr_ff;
      chk_idx_in = chk_idx_ff;
      pfree_idx_in = pfree_idx_ff;
      issue_in = issue_ff;
      chk_valid_in = chk_valid_ff;
      pfree_valid_in = pfree_valid_ff;
      if (cmd.pair_start) begin
         pair_ptr_in = '0;
         issue_in = 1'b1;
         chk_valid_in = 1'b0;
         pfree_valid_in = 1'b0;
      end else if (cmd.pair_adv) begin
         chk_valid_in = issue_ff;
         chk_idx_in = pair_ptr_ff;
         if (issue_ff) begin
            if (pair_ptr_ff == PAIR_W'(PAIRS_PER_DOMAIN - 1)) begin
               issue_in = 1'b0;
            end else begin
               pair_ptr_in = pair_ptr_ff + 1'b1;
            end
         end
         if (chk_valid_ff && !chk_used && !pfree_valid_ff) begin
            pfree_valid_in = 1'b1;
            pfree_idx_in = chk_idx_ff;
         end
      end
   end

   always_comb begin
      pair_used_in = pair_used_ff;
      if (cmd.pair_write) begin
         pair_used_in[pick_addr] = 1'b1;
      end
      if (cmd.pair_clear_one) begin
         pair_used_in[chk_addr] = 1'b0;
      end
      if (cmd.pair_clear_row) begin
         for (int k = 0; k < PAIRS_PER_DOMAIN; k++) begin
            pair_used_in[base + ENTRY_W'(k)] = 1'b0;
         end
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_group_in = pend_group_ff;
      list_cnt_in = list_cnt_ff;
      if (cmd.load) begin
         pend_valid_in = 1'b0;
         list_cnt_in = '0;
      end else if (cmd.list_take) begin
         pend_valid_in = 1'b1;
         pend_group_in = rd_group_ff;
         list_cnt_in = list_cnt_ff + 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in = rsp_found_ff;
      rsp_group_in = rsp_group_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in = cmd.emit_last;
         unique case (cmd.emit_sel)
            EMIT_PEND: begin
               rsp_status_in = ST_OK;
               rsp_found_in = 1'b1;
               rsp_group_in = pend_group_ff;
            end
            EMIT_CODE: begin
               rsp_status_in = cmd.emit_status;
               rsp_found_in = cmd.emit_found;
               rsp_group_in = '0;
            end
            default: begin
               rsp_status_in = cmd.emit_status;
               rsp_found_in = cmd.emit_found;
               rsp_group_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         slot_used_ff <= '0;
         slot_ptr_ff <= '0;
         sfree_valid_ff <= 1'b0;
         pair_used_ff <= '0;
         pair_ptr_ff <= '0;
         issue_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
         pfree_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         list_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
         slot_used_ff <= slot_used_in;
         slot_ptr_ff <= slot_ptr_in;
         sfree_valid_ff <= sfree_valid_in;
         pair_used_ff <= pair_used_in;
         pair_ptr_ff <= pair_ptr_in;
         issue_ff <= issue_in;
         chk_valid_ff <= chk_valid_in;
         pfree_valid_ff <= pfree_valid_in;
         pend_valid_ff <= pend_valid_in;
         list_cnt_ff <= list_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff <= item_cmd_in;
      dom_ff <= dom_in;
      grp_ff <= grp_in;
      ep_ff <= ep_in;
      slot_domain_ff <= slot_domain_in;
      slot_sel_ff <= slot_sel_in;
      sfree_idx_ff <= sfree_idx_in;
      chk_idx_ff <= chk_idx_in;
      pfree_idx_ff <= pfree_idx_in;
      pend_group_ff <= pend_group_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff <= rsp_found_in;
      rsp_group_ff <= rsp_group_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Pair memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.pair_write) begin
         pair_mem[pick_addr] <= {grp_ff, ep_ff};
      end
      if (cmd.pair_adv && issue_ff) begin
         {rd_group_ff, rd_ep_ff} <= pair_mem[rd_addr];
      end
   end

   assign sts.enabled = enabled_ff;
   assign sts.command = item_cmd_ff;
   assign sts.slot_end = slot_end;
   assign sts.slot_found = slot_found;
   assign sts.chk_valid = chk_valid_ff;
   assign sts.chk_last = chk_last;
   assign sts.chk_match = chk_match;
   assign sts.chk_ep_match = chk_ep_match;
   assign sts.pfree_any = pfree_any;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.list_full = (list_cnt_ff == CNT_W'(MAX_RESULTS - 1));
   assign sts.out_free = out_free;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.found = rsp_found_ff;
   assign rsp.listed_group = rsp_group_ff;
   assign rsp.last = rsp_last_ff;

endmodule

>>> rtl/gemt_ctrl.sv
`timescale 1ns / 1ps

module gemt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gemt_pkg::gemt_sts_type sts,
   output gemt_pkg::gemt_cmd_type cmd
);
   import gemt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SLOT,
      S_PAIR,
      S_LIST_END,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [STATUS_W-1:0] resp_status_ff, resp_status_in;
   logic resp_found_ff, resp_found_in;
   logic stall;

   always_comb begin
      state_in = state_ff;
      resp_status_in = resp_status_ff;
      resp_found_in = resp_found_ff;
      cmd = '0;
      req_ready = 1'b0;
      stall = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            resp_found_in = 1'b0;
            priority if (sts.command > CMD_LIST) begin
               state_in = S_IDLE;
            end else if (!sts.enabled) begin
               resp_status_in = ST_NOT_READY;
               state_in = S_RESP;
            end else begin
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            cmd.slot_step = 1'b1;
            if (sts.slot_end) begin
               priority if (sts.slot_found) begin
                  cmd.pair_start = 1'b1;
                  state_in = S_PAIR;
               end else if (sts.command == CMD_LIST) begin
                  state_in = S_LIST_END;
               end else if (sts.command == CMD_EXISTS) begin
                  resp_status_in = ST_OK;
                  state_in = S_RESP;
               end else if (sts.command == CMD_ADD) begin
                  resp_status_in = ST_NO_ROOM;
                  state_in = S_RESP;
               end else begin
                  resp_status_in = ST_UNKNOWN_DOMAIN;
                  state_in = S_RESP;
               end
            end
         end
         S_PAIR: begin
            if (sts.command == CMD_REMOVE_ALL) begin
               cmd.pair_clear_row = 1'b1;
               resp_status_in = ST_OK;
               state_in = S_RESP;
            end else begin
               // A list match must hand its predecessor to the output register first.
               stall = (sts.command == CMD_LIST) && sts.chk_valid && sts.chk_ep_match &&
                       sts.pend_valid && !sts.out_free;
               if (!stall) begin
                  cmd.pair_adv = 1'b1;
                  if (sts.chk_valid) begin
                     priority if (sts.command == CMD_LIST) begin
                        if (sts.chk_ep_match) begin
                           cmd.list_take = 1'b1;
                           if (sts.pend_valid) begin
                              cmd.emit = 1'b1;
                              cmd.emit_sel = EMIT_PEND;
                           end
                           if (sts.list_full) begin
                              state_in = S_LIST_END;
                           end
                        end
                        if (sts.chk_last) begin
                           state_in = S_LIST_END;
                        end
                     end else if (sts.chk_match) begin
                        resp_status_in = ST_OK;
                        resp_found_in = (sts.command == CMD_EXISTS);
                        cmd.pair_clear_one = (sts.command == CMD_REMOVE);
                        state_in = S_RESP;
                     end else if (sts.chk_last) begin
                        state_in = S_RESP;
                        priority if (sts.command == CMD_EXISTS) begin
                           resp_status_in = ST_OK;
                        end else if (sts.command == CMD_ADD) begin
                           cmd.pair_write = sts.pfree_any;
                           resp_status_in = sts.pfree_any ? ST_OK : ST_NO_ROOM;
                        end else begin
                           resp_status_in = ST_NOT_FOUND;
                        end
                     end
                  end
               end
            end
         end
         S_LIST_END: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_last = 1'b1;
               if (sts.pend_valid) begin
                  cmd.emit_sel = EMIT_PEND;
               end else begin
                  cmd.emit_sel = EMIT_CODE;
                  cmd.emit_status = ST_OK;
                  cmd.emit_found = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = EMIT_CODE;
               cmd.emit_status = resp_status_ff;
               cmd.emit_found = resp_found_ff;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         resp_status_ff <= ST_OK;
         resp_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         resp_status_ff <= resp_status_in;
         resp_found_ff <= resp_found_in;
      end
   end

endmodule

>>> rtl/group_endpoint_mapping_table.sv
`timescale 1ns / 1ps
// Flow: an item is decoded, then, when enabled, scans the domain slots one slot per step (ending
// at the matching slot or the last slot), scans the pairs through the registered read port of
// the pair memory and loads its result into the output register; output stalls can hold it.
// Items: one at a time; the next is accepted the cycle
// after the final result is loaded. A list result trails the scan by one match.
// Reset: synchronous; clears the enable, all used flags and the control state at once.
`include "assert_macros.svh"

module group_endpoint_mapping_table (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   gemt_req_if.sink   req,
   gemt_rsp_if.source rsp
);
   import gemt_pkg::*;

   gemt_cmd_type ctl_cmd;
   gemt_sts_type dp_sts;

   gemt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   gemt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_command     (req.command),
      .req_fabric_id   (req.fabric_id),
      .req_group_id    (req.group_id),
      .req_endpoint_id (req.endpoint_id),
      .cmd             (ctl_cmd),
      .sts             (dp_sts),
      .rsp             (rsp)
   );

   `GEMT_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req.valid && req.ready, !req.ready, "item accepted while another is in progress")
   `GEMT_ASSERT_SAME(a_emit_into_free_slot, clock, reset, ctl_cmd.emit, dp_sts.out_free, "result loaded over one not yet taken")
   `GEMT_ASSERT_SAME(a_pending_emit_valid, clock, reset, ctl_cmd.emit && (ctl_cmd.emit_sel == EMIT_PEND), dp_sts.pend_valid, "list result emitted with nothing pending")
   `GEMT_ASSERT_SAME(a_non_last_is_list_hit, clock, reset, rsp.valid && !rsp.last, rsp.found && (rsp.status == ST_OK), "non-final result is not a listed group")

endmodule

>>> tb/sv/tb_group_endpoint_mapping_table.sv
`timescale 1ns / 1ps

module tb_group_endpoint_mapping_table;
   import gemt_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT = 5000;
   localparam int ITEM_TARGET = 310;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT = 80;
   localparam int DISABLE_AT = 170;
   localparam int REPORT_LIMIT = 10;
   localparam int DOMAIN_POOL = 20;
   localparam int GROUP_POOL = 6;
   localparam int ENDPOINT_POOL = 4;
   localparam int DIRECTED_ROWS = 25;
   localparam int DISABLED_ROWS = 3;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic found;
      logic [GROUP_W-1:0] group;
      logic last;
   } reply_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [FABRIC_W-1:0] fabric;
      logic [GROUP_W-1:0] group;
      logic [ENDPOINT_W-1:0] endpoint;
      logic typed;
      logic [STATUS_W-1:0] status;
      logic found;
   } row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   gemt_req_if req_ch ();
   gemt_rsp_if rsp_ch ();

   group_endpoint_mapping_table DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   // Mirror of the table contents and the enable register.
   bit enable_q;
   bit dom_used [DOMAIN_SLOTS];
   logic [FABRIC_W-1:0] dom_id [DOMAIN_SLOTS];
   bit entry_used [TOTAL_PAIRS];
   logic [GROUP_W-1:0] entry_group [TOTAL_PAIRS];
   logic [ENDPOINT_W-1:0] entry_ep [TOTAL_PAIRS];

   reply_type predicted_now[$];
   reply_type expected_replies[$];

   logic [FABRIC_W-1:0] domain_pool [DOMAIN_POOL];
   logic [GROUP_W-1:0] group_pool [GROUP_POOL];
   logic [ENDPOINT_W-1:0] endpoint_pool [ENDPOINT_POOL];

   int items_done;
   int replies_seen;
   int found_seen;
   int no_room_seen;
   int fail_count;
   bit hold_request;

   row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_EXISTS,     8'h00, 16'h0000, 16'h0000, 1'b1, ST_NOT_READY,      1'b0},
      '{CMD_ADD,        8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_NOT_READY,      1'b0},
      '{CMD_LIST,       8'hFF, 16'h0000, 16'hFFFF, 1'b1, ST_NOT_READY,      1'b0},
      '{CMD_EXISTS,     8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,             1'b0},
      '{CMD_REMOVE,     8'h00, 16'h0000, 16'h0000, 1'b1, ST_UNKNOWN_DOMAIN, 1'b0},
      '{CMD_REMOVE_ALL, 8'hFF, 16'h0000, 16'hFFFF, 1'b1, ST_UNKNOWN_DOMAIN, 1'b0},
      '{CMD_LIST,       8'hFF, 16'h0000, 16'hFFFF, 1'b1, ST_OK,             1'b0},
      '{CMD_ADD,        8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,             1'b0},
      '{CMD_ADD,        8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,             1'b0},
      '{CMD_ADD,        8'h00, 16'hFFFF, 16'h0000, 1'b1, ST_OK,             1'b0},
      '{CMD_ADD,        8'h00, 16'h5A5A, 16'hFFFF, 1'b1, ST_OK,             1'b0},
      '{CMD_EXISTS,     8'h00, 16'hFFFF, 16'h0000, 1'b1, ST_OK,             1'b1},
      '{CMD_EXISTS,     8'h00, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK,             1'b0},
      '{CMD_LIST,       8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,             1'b0},
      '{CMD_REMOVE,     8'h00, 16'h0001, 16'h0000, 1'b1, ST_NOT_FOUND,      1'b0},
      '{CMD_REMOVE,     8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,             1'b0},
      '{CMD_LIST,       8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,             1'b0},
      '{CMD_ADD,        8'hFF, 16'hA5A5, 16'hFFFF, 1'b1, ST_OK,             1'b0},
      '{CMD_SPARE_LO,   8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK,             1'b0},
      '{CMD_SPARE_HI,   8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,             1'b0},
      '{CMD_REMOVE_ALL, 8'hFF, 16'h0000, 16'h1234, 1'b1, ST_OK,             1'b0},
      '{CMD_EXISTS,     8'hFF, 16'hA5A5, 16'hFFFF, 1'b1, ST_OK,             1'b0},
      '{CMD_LIST,       8'h00, 16'h0000, 16'hFFFF, 1'b0, ST_OK,             1'b0},
      '{CMD_ADD,        8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,             1'b0},
      '{CMD_LIST,       8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,             1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results still expected", expected_replies.size());
      $display("status: fail");
      $finish;
   end

   // Returns the slot of a domain, or -1; an add claims the lowest free slot.
   function automatic int find_domain(input logic [FABRIC_W-1:0] fab, input bit claim);
      int free_idx;
      int s;
      free_idx = -1;
      for (s = 0; s < DOMAIN_SLOTS; s++) begin
         if (dom_used[s]) begin
            if (dom_id[s] == fab) return s;
         end else if (free_idx < 0) begin
            free_idx = s;
         end
      end
      if (claim && free_idx >= 0) begin
         dom_used[free_idx] = 1'b1;
         dom_id[free_idx] = fab;
      end
      return claim ? free_idx : -1;
   endfunction

   function automatic int find_entry(input int base, input logic [GROUP_W-1:0] grp,
                                     input logic [ENDPOINT_W-1:0] ep);
      int i;
      for (i = 0; i < PAIRS_PER_DOMAIN; i++) begin
         if (entry_used[base + i] && entry_group[base + i] == grp && entry_ep[base + i] == ep)
            return base + i;
      end
      return -1;
   endfunction

   function automatic void push_reply(input logic [STATUS_W-1:0] st, input logic fnd,
                                      input logic [GROUP_W-1:0] grp, input logic lst);
      reply_type r;
      r.status = st;
      r.found = fnd;
      r.group = grp;
      r.last = lst;
      predicted_now.push_back(r);
   endfunction

   // Applies one command to the mirror and leaves its replies in predicted_now.
   function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                         input logic [FABRIC_W-1:0] fab,
                                         input logic [GROUP_W-1:0] grp,
                                         input logic [ENDPOINT_W-1:0] ep);
      int slot;
      int base;
      int e;
      int i;
      reply_type tail;
      predicted_now.delete();
      if (cmd > CMD_LIST) return;
      if (!enable_q) begin
         push_reply(ST_NOT_READY, 1'b0, '0, 1'b1);
         return;
      end
      slot = find_domain(fab, cmd == CMD_ADD);
      base = (slot < 0) ? 0 : slot * PAIRS_PER_DOMAIN;
      case (cmd)
         CMD_EXISTS: begin
            push_reply(ST_OK, slot >= 0 && find_entry(base, grp, ep) >= 0, '0, 1'b1);
         end
         CMD_ADD: begin
            if (slot < 0) begin
               push_reply(ST_NO_ROOM, 1'b0, '0, 1'b1);
            end else if (find_entry(base, grp, ep) >= 0) begin
               push_reply(ST_OK, 1'b0, '0, 1'b1);
            end else begin
               e = -1;
               for (i = 0; i < PAIRS_PER_DOMAIN; i++)
                  if (e < 0 && !entry_used[base + i]) e = base + i;
               if (e < 0) begin
                  push_reply(ST_NO_ROOM, 1'b0, '0, 1'b1);
               end else begin
                  entry_used[e] = 1'b1;
                  entry_group[e] = grp;
                  entry_ep[e] = ep;
                  push_reply(ST_OK, 1'b0, '0, 1'b1);
               end
            end
         end
         CMD_REMOVE: begin
            if (slot < 0) begin
               push_reply(ST_UNKNOWN_DOMAIN, 1'b0, '0, 1'b1);
            end else begin
               e = find_entry(base, grp, ep);
               if (e < 0) begin
                  push_reply(ST_NOT_FOUND, 1'b0, '0, 1'b1);
               end else begin
                  entry_used[e] = 1'b0;
                  push_reply(ST_OK, 1'b0, '0, 1'b1);
               end
            end
         end
         CMD_REMOVE_ALL: begin
            if (slot < 0) begin
               push_reply(ST_UNKNOWN_DOMAIN, 1'b0, '0, 1'b1);
            end else begin
               for (i = 0; i < PAIRS_PER_DOMAIN; i++) entry_used[base + i] = 1'b0;
               push_reply(ST_OK, 1'b0, '0, 1'b1);
            end
         end
         default: begin
            if (slot >= 0) begin
               for (i = 0; i < PAIRS_PER_DOMAIN; i++)
                  if (predicted_now.size() < MAX_RESULTS && entry_used[base + i] &&
                      entry_ep[base + i] == ep)
                     push_reply(ST_OK, 1'b1, entry_group[base + i], 1'b0);
            end
            if (predicted_now.size() == 0) begin
               push_reply(ST_OK, 1'b0, '0, 1'b1);
            end else begin
               tail = predicted_now.pop_back();
               tail.last = 1'b1;
               predicted_now.push_back(tail);
            end
         end
      endcase
   endfunction

   function automatic bit quiet_phase();
      return (items_done / 40) % 3 == 2;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endfunction

   task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [FABRIC_W-1:0] fab,
                                input logic [GROUP_W-1:0] grp,
                                input logic [ENDPOINT_W-1:0] ep, input bit typed,
                                input logic [STATUS_W-1:0] st, input logic fnd);
      int gap;
      reply_type r;
      gap = quiet_phase() ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.command <= cmd;
      req_ch.fabric_id <= fab;
      req_ch.group_id <= grp;
      req_ch.endpoint_id <= ep;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      apply_command(cmd, fab, grp, ep);
      if (typed) begin
         r.status = st;
         r.found = fnd;
         r.group = '0;
         r.last = 1'b1;
         expected_replies.push_back(r);
      end else begin
         foreach (predicted_now[i]) expected_replies.push_back(predicted_now[i]);
      end
      if (cmd <= CMD_LIST) items_done++;
   endtask

   task automatic offer(input logic [CMD_W-1:0] cmd, input logic [FABRIC_W-1:0] fab,
                        input logic [GROUP_W-1:0] grp, input logic [ENDPOINT_W-1:0] ep);
      offer_command(cmd, fab, grp, ep, 1'b0, ST_OK, 1'b0);
   endtask

   function automatic logic [FABRIC_W-1:0] pick_domain();
      return domain_pool[$urandom_range(0, DOMAIN_POOL - 1)];
   endfunction

   function automatic logic [GROUP_W-1:0] pick_group();
      if ($urandom_range(0, 1) == 0) return group_pool[$urandom_range(0, GROUP_POOL - 1)];
      return GROUP_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [ENDPOINT_W-1:0] pick_endpoint();
      if ($urandom_range(0, 4) != 0)
         return endpoint_pool[$urandom_range(0, ENDPOINT_POOL - 1)];
      return ENDPOINT_W'($urandom_range(0, 65535));
   endfunction

   // Waits for every expected item or the drain limit, then gives a command with no reply time to finish.
   task automatic settle();
      int waited;
      waited = 0;
      while (expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input bit value);
      req_ch.valid <= 1'b0;
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      enable_q = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_reply();
      reply_type got;
      reply_type want;
      got.status = rsp_ch.status;
      got.found = rsp_ch.found;
      got.group = rsp_ch.listed_group;
      got.last = rsp_ch.last;
      replies_seen++;
      if (got.found === 1'b1) found_seen++;
      if (got.status === ST_NO_ROOM) no_room_seen++;
      if (expected_replies.size() == 0) begin
         note_failure($sformatf("unexpected item: st %0d found %0d group %h last %0d",
                                got.status, got.found, got.group, got.last));
      end else begin
         want = expected_replies.pop_front();
         if (got.status !== want.status || got.found !== want.found ||
             got.group !== want.group || got.last !== want.last)
            note_failure($sformatf({"mismatch: st %0d/%0d found %0d/%0d group %h/%h ",
                                    "last %0d/%0d (expected/actual)"},
                                   want.status, got.status, want.found, got.found,
                                   want.group, got.group, want.last, got.last));
      end
   endtask

   // Result side: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = quiet_phase() ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         check_reply();
      end
   end

   initial begin
      int kind;
      int n;
      int r;
      bit hold_done;
      bit disable_done;
      logic [FABRIC_W-1:0] dom;
      logic [ENDPOINT_W-1:0] ep;

      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_EXISTS;
      req_ch.fabric_id <= '0;
      req_ch.group_id <= '0;
      req_ch.endpoint_id <= '0;
      hold_done = 1'b0;
      disable_done = 1'b0;

      domain_pool[0] = 8'h00;
      domain_pool[1] = 8'hFF;
      for (r = 2; r < DOMAIN_POOL; r++) domain_pool[r] = FABRIC_W'($urandom_range(1, 254));
      for (r = 0; r < GROUP_POOL; r++) group_pool[r] = GROUP_W'($urandom_range(0, 65535));
      endpoint_pool[0] = 16'h0000;
      endpoint_pool[1] = 16'hFFFF;
      for (r = 2; r < ENDPOINT_POOL; r++)
         endpoint_pool[r] = ENDPOINT_W'($urandom_range(0, 65535));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_enable(1'b0);
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         if (r == DISABLED_ROWS) write_enable(1'b1);
         offer_command(directed_rows[r].command, directed_rows[r].fabric,
                       directed_rows[r].group, directed_rows[r].endpoint,
                       directed_rows[r].typed, directed_rows[r].status,
                       directed_rows[r].found);
      end

      while (items_done < ITEM_TARGET) begin
         if (!hold_done && items_done >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_request = 1'b1;
         end
         if (!disable_done && items_done >= DISABLE_AT) begin
            disable_done = 1'b1;
            write_enable(1'b0);
            repeat (6) offer(CMD_W'($urandom_range(0, 4)), pick_domain(), pick_group(),
                             pick_endpoint());
            write_enable(1'b1);
         end
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               // Fill a domain for one endpoint, then list it back.
               dom = pick_domain();
               ep = pick_endpoint();
               n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
               repeat (n) offer(CMD_ADD, dom, pick_group(), ep);
               offer(CMD_LIST, dom, GROUP_W'($urandom_range(0, 65535)), ep);
               if ($urandom_range(0, 1) == 0) offer(CMD_EXISTS, dom, pick_group(), ep);
            end
            4, 5: begin
               if ($urandom_range(0, 3) == 0)
                  offer(CMD_REMOVE_ALL, pick_domain(), pick_group(), pick_endpoint());
               else
                  offer(CMD_REMOVE, pick_domain(), pick_group(), pick_endpoint());
            end
            6, 7: begin
               offer(CMD_W'($urandom_range(0, 4)), pick_domain(), pick_group(),
                     pick_endpoint());
            end
            8: begin
               offer(CMD_W'($urandom_range(0, 7)), FABRIC_W'($urandom_range(0, 255)),
                     GROUP_W'($urandom_range(0, 65535)), ENDPOINT_W'($urandom_range(0, 65535)));
            end
            default: begin
               dom = pick_domain();
               offer(CMD_REMOVE_ALL, dom, pick_group(), pick_endpoint());
               offer(CMD_LIST, dom, pick_group(), pick_endpoint());
            end
         endcase
      end

      req_ch.valid <= 1'b0;
      settle();
      if (expected_replies.size() != 0)
         note_failure($sformatf("%0d expected items never arrived", expected_replies.size()));

      $display("Ran %0d table commands, directed and random, with the table enabled and disabled.",
               items_done);
      $display("Checked %0d result items: %0d with found set, %0d refused for lack of room.",
               replies_seen, found_seen, no_room_seen);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
